### rtl/radial_stick_dead_zone_defines.svh
// Assertion macros shared by the RTL.
`ifndef RADIAL_STICK_DEAD_ZONE_DEFINES_SVH
`define RADIAL_STICK_DEAD_ZONE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RSDZ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define RSDZ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/rsdz_pkg.sv
`default_nettype none
package rsdz_pkg;

  localparam int SQRT_STEPS = 16;
  localparam int DIV_STEPS  = 17;

  localparam logic [14:0] DZ_RESET  = 15'd4915;
  localparam logic [15:0] ONE_Q15   = 16'h8000;
  localparam logic [16:0] SAT_POS   = 17'h0FFFF;
  localparam logic [16:0] SAT_NEG   = 17'h10000;

  // register index, taken from paddr[2]
  localparam logic REG_DEAD_ZONE = 1'b0;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        t;
    logic [31:0]        s;
    logic               dz;
  } sq_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        t;
    logic [15:0]        m;
    logic               dz;
  } mag_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        t;
    logic               dz;
    logic [31:0]        rem;
    logic [31:0]        res;
  } sqs_t;

  typedef struct packed {
    logic        sx;
    logic        sy;
    logic        dz;
    logic        mz;
    logic        ovx;
    logic        ovy;
    logic [32:0] d;
    logic [48:0] rx;
    logic [48:0] ry;
    logic [16:0] qx;
    logic [16:0] qy;
  } dvs_t;

endpackage
`default_nettype wire

### rtl/rsdz_square.sv
`default_nettype none
module rsdz_square (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] x,
  input  wire logic signed [15:0] y,
  input  wire logic [14:0]        t,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rsdz_pkg::sq_t           out_data
);
  import rsdz_pkg::*;

  logic               va, vb, rdy_a, rdy_b;
  logic signed [15:0] xa, ya;
  logic [14:0]        ta;
  logic [30:0]        xx, yy;
  logic [29:0]        tt;
  logic signed [31:0] px, py;
  logic [31:0]        s;

  assign rdy_b    = !vb || !out_stall;
  assign rdy_a    = !va || rdy_b;
  assign in_stall = !rdy_a;
  assign px       = x * x;
  assign py       = y * y;
  assign s        = {1'b0, xx} + {1'b0, yy};

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      if (rdy_a) va <= in_valid;
      if (rdy_b) vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      xa <= x;
      ya <= y;
      ta <= t;
      xx <= px[30:0];
      yy <= py[30:0];
      tt <= t * t;
    end
    if (rdy_b && va) begin
      out_data.x  <= xa;
      out_data.y  <= ya;
      out_data.t  <= ta;
      out_data.s  <= s;
      out_data.dz <= s < {2'b0, tt};
    end
  end

  assign out_valid = vb;
endmodule
`default_nettype wire

### rtl/rsdz_sqrt.sv
`default_nettype none
module rsdz_sqrt (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire rsdz_pkg::sq_t  in_data,
  output logic         out_valid,
  input  wire logic    out_stall,
  output rsdz_pkg::mag_t out_data
);
  import rsdz_pkg::*;

  sqs_t                  st  [SQRT_STEPS];
  sqs_t                  src [SQRT_STEPS];
  logic [SQRT_STEPS-1:0] vld, rdy, pv, nstall;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [32:0] BIT = 33'd1 << (30 - 2 * k);
    logic [32:0] trial;
    sqs_t        nxt;

    if (k > 0) begin : g_link
      assign src[k] = st[k-1];
      assign pv[k]  = vld[k-1];
    end else begin : g_head
      assign src[k] = sqs_t'{x: in_data.x, y: in_data.y, t: in_data.t, dz: in_data.dz,
                             rem: in_data.s, res: '0};
      assign pv[k]  = in_valid;
    end
    if (k == SQRT_STEPS - 1) begin : g_last
      assign nstall[k] = out_stall;
    end else begin : g_mid
      assign nstall[k] = !rdy[k+1];
    end
    assign rdy[k] = !vld[k] || !nstall[k];

    // one result bit per stage
    always_comb begin
      nxt   = src[k];
      trial = {1'b0, src[k].res} + BIT;
      if ({1'b0, src[k].rem} >= trial) begin
        nxt.rem = src[k].rem - trial[31:0];
        nxt.res = (src[k].res >> 1) + BIT[31:0];
      end else begin
        nxt.res = src[k].res >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= pv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && pv[k]) st[k] <= nxt;
    end
  end

  assign in_stall    = !rdy[0];
  assign out_valid   = vld[SQRT_STEPS-1];
  assign out_data.x  = st[SQRT_STEPS-1].x;
  assign out_data.y  = st[SQRT_STEPS-1].y;
  assign out_data.t  = st[SQRT_STEPS-1].t;
  assign out_data.dz = st[SQRT_STEPS-1].dz;
  assign out_data.m  = st[SQRT_STEPS-1].res[15:0];
endmodule
`default_nettype wire

### rtl/rsdz_scale.sv
`default_nettype none
module rsdz_scale (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire rsdz_pkg::mag_t in_data,
  output logic         out_valid,
  input  wire logic    out_stall,
  output logic [16:0]  x_out,
  output logic [16:0]  y_out,
  output logic         dz_out
);
  import rsdz_pkg::*;

  localparam int NS    = DIV_STEPS + 4;
  localparam int D0    = 3;
  localparam int LAST  = NS - 1;

  logic [NS-1:0] vld, rdy, pv, nstall;

  // stage 0: products
  logic        s0_sx, s0_sy, s0_dz, s0_mz;
  logic [31:0] s0_px, s0_py, s0_den;
  // stage 1: rounded numerators, doubled divisor
  logic        s1_sx, s1_sy, s1_dz, s1_mz;
  logic [48:0] s1_nx, s1_ny;
  logic [32:0] s1_d;

  logic [16:0] ax, ay;
  logic [15:0] dm, omt;
  logic [32:0] prx, pry;
  logic [49:0] dlim;

  dvs_t dv  [DIV_STEPS];
  dvs_t dsrc[DIV_STEPS];
  dvs_t s2;

  assign ax   = in_data.x[15] ? (~{in_data.x[15], in_data.x} + 17'd1) : {1'b0, in_data.x};
  assign ay   = in_data.y[15] ? (~{in_data.y[15], in_data.y} + 17'd1) : {1'b0, in_data.y};
  assign dm   = in_data.m - {1'b0, in_data.t};
  assign omt  = ONE_Q15 - {1'b0, in_data.t};
  assign prx  = ax * dm;
  assign pry  = ay * dm;
  assign dlim = {17'b0, s1_d} << DIV_STEPS;

  assign pv[0] = in_valid;
  for (genvar k = 0; k < NS; k++) begin : g_ctl
    if (k > 0) begin : g_pv
      assign pv[k] = vld[k-1];
    end
    if (k == LAST) begin : g_last
      assign nstall[k] = out_stall;
    end else begin : g_mid
      assign nstall[k] = !rdy[k+1];
    end
    assign rdy[k] = !vld[k] || !nstall[k];
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= pv[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && pv[0]) begin
      s0_sx  <= in_data.x[15];
      s0_sy  <= in_data.y[15];
      s0_dz  <= in_data.dz;
      s0_mz  <= in_data.m == 16'd0;
      s0_px  <= prx[31:0];
      s0_py  <= pry[31:0];
      s0_den <= omt * in_data.m;
    end
    if (rdy[1] && pv[1]) begin
      s1_sx <= s0_sx;
      s1_sy <= s0_sy;
      s1_dz <= s0_dz;
      s1_mz <= s0_mz;
      s1_nx <= {1'b0, s0_px, 16'b0} + {17'b0, s0_den};
      s1_ny <= {1'b0, s0_py, 16'b0} + {17'b0, s0_den};
      s1_d  <= {s0_den, 1'b0};
    end
    if (rdy[2] && pv[2]) begin
      s2.sx  <= s1_sx;
      s2.sy  <= s1_sy;
      s2.dz  <= s1_dz;
      s2.mz  <= s1_mz;
      s2.ovx <= {1'b0, s1_nx} >= dlim;
      s2.ovy <= {1'b0, s1_ny} >= dlim;
      s2.d   <= s1_d;
      s2.rx  <= s1_nx;
      s2.ry  <= s1_ny;
      s2.qx  <= '0;
      s2.qy  <= '0;
    end
  end

  // restoring division, one quotient bit per stage, msb first
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int B = DIV_STEPS - 1 - j;
    logic [49:0] dsh;
    dvs_t        nxt;

    if (j == 0) begin : g_first
      assign dsrc[j] = s2;
    end else begin : g_rest
      assign dsrc[j] = dv[j-1];
    end
    assign dsh = {17'b0, dsrc[j].d} << B;

    always_comb begin
      nxt = dsrc[j];
      if ({1'b0, dsrc[j].rx} >= dsh) begin
        nxt.rx    = dsrc[j].rx - dsh[48:0];
        nxt.qx[B] = 1'b1;
      end
      if ({1'b0, dsrc[j].ry} >= dsh) begin
        nxt.ry    = dsrc[j].ry - dsh[48:0];
        nxt.qy[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[D0+j] && pv[D0+j]) dv[j] <= nxt;
    end
  end

  function automatic logic [16:0] sat_sign(input logic neg, input logic ov,
                                           input logic [16:0] q);
    logic [16:0] mag;
    mag = {1'b0, q[15:0]};
    if (ov || q[16]) sat_sign = neg ? SAT_NEG : SAT_POS;
    else             sat_sign = neg ? (~mag + 17'd1) : mag;
  endfunction

  dvs_t fin;
  assign fin = dv[DIV_STEPS-1];

  always_ff @(posedge clk) begin
    if (rdy[LAST] && pv[LAST]) begin
      dz_out <= fin.dz;
      if (fin.dz || fin.mz) begin
        x_out <= '0;
        y_out <= '0;
      end else begin
        x_out <= sat_sign(fin.sx, fin.ovx, fin.qx);
        y_out <= sat_sign(fin.sy, fin.ovy, fin.qy);
      end
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld[LAST];
endmodule
`default_nettype wire

### rtl/radial_stick_dead_zone.sv
// Pipeline from an accepted input transaction to its result
// (2 squaring stages, 16 square-root stages, 21 scaling/division stages).
// Throughput: one transaction per cycle unstalled; bubbles close under stall.
// Reset: synchronous, active high; empties the pipeline, dead_zone to 4915.
`default_nettype none
`include "radial_stick_dead_zone_defines.svh"
module radial_stick_dead_zone (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  // sample in
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] axis_x_in,
  input  wire logic signed [15:0] axis_y_in,
  // result out
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [16:0]      axis_x_out,
  output logic signed [16:0]      axis_y_out,
  output logic                    in_dead_zone
);
  import rsdz_pkg::*;

  logic [14:0] dead_zone;
  logic        cfg_wr;

  // threshold register; only index 0 exists, higher addresses are ignored
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_DEAD_ZONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_zone <= DZ_RESET;
    end else if (cfg_wr) begin
      dead_zone <= pwdata[14:0];
    end
  end

  assign prdata = (paddr[2] == REG_DEAD_ZONE) ? {17'b0, dead_zone} : 32'b0;

  // squaring front end: s = x*x + y*y and the exact s < t*t test
  sq_t  sq_d;
  logic sq_v, sq_stall;
  mag_t mg_d;
  logic mg_v, mg_stall;
  logic [16:0] xo, yo;

  rsdz_square u_square (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .x         (axis_x_in),
    .y         (axis_y_in),
    .t         (dead_zone),
    .out_valid (sq_v),
    .out_stall (sq_stall),
    .out_data  (sq_d)
  );

  // floor square root, one result bit per stage
  rsdz_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_v),
    .in_stall  (sq_stall),
    .in_data   (sq_d),
    .out_valid (mg_v),
    .out_stall (mg_stall),
    .out_data  (mg_d)
  );

  // scale factor (m - t) / ((1 - t) m), rounded half away from zero, saturated
  rsdz_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mg_v),
    .in_stall  (mg_stall),
    .in_data   (mg_d),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .x_out     (xo),
    .y_out     (yo),
    .dz_out    (in_dead_zone)
  );

  assign axis_x_out = signed'(xo);
  assign axis_y_out = signed'(yo);

  `RSDZ_ASSERT_IMPL(a_dz_zero, out_valid && in_dead_zone, axis_x_out == 17'sd0 && axis_y_out == 17'sd0, "dead zone result not zero")
  `RSDZ_ASSERT_IMPL(a_empty_ready, !out_valid, !in_stall, "input stalled with empty output")
  `RSDZ_ASSERT_IMPL(a_stall_src, in_stall, out_stall, "input stalled without output stall")
  `RSDZ_ASSERT_NEXT(a_cfg_wr, cfg_wr, dead_zone == $past(pwdata[14:0]), "dead_zone write lost")
endmodule
`default_nettype wire
